>>> rtl/mpbc_pkg.sv
// Shared constants, register codes and types of the multi-press burst counter.
`timescale 1ns / 1ps

package mpbc_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int TIME_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    // Input beat: pin_level, now_ms; output beat: burst_done, burst_count.
    localparam int IN_BITS       = 1 + TIME_WIDTH;
    localparam int IN_DATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = 1 + COUNT_WIDTH;
    localparam int OUT_DATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_GAP = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FROM_LEVEL = 2'd2;

    localparam logic [TIME_WIDTH-1:0] REPEAT_GAP_RESET = TIME_WIDTH'(400);
    localparam logic [TIME_WIDTH-1:0] DEBOUNCE_RESET   = TIME_WIDTH'(50);
    localparam logic                  FROM_LEVEL_RESET = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic [TIME_WIDTH-1:0] repeat_gap_ms;
        logic [TIME_WIDTH-1:0] debounce_ms;
        logic                  from_level;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] burst_count;
        logic                   burst_done;
    } result_t;

endpackage

>>> rtl/mpbc_cfg_regs.sv
// Configuration register file of the multi-press burst counter.
`timescale 1ns / 1ps

module mpbc_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mpbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mpbc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output mpbc_pkg::cfg_t                       cfg
);

    mpbc_pkg::cfg_t cfg_reg;
    logic           wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_gap_ms <= mpbc_pkg::REPEAT_GAP_RESET;
            cfg_reg.debounce_ms   <= mpbc_pkg::DEBOUNCE_RESET;
            cfg_reg.from_level    <= mpbc_pkg::FROM_LEVEL_RESET;
        end
        else if (wr)
        begin
            unique case (cfg_index)
                mpbc_pkg::REG_REPEAT_GAP:
                    cfg_reg.repeat_gap_ms <= cfg_data[mpbc_pkg::TIME_WIDTH-1:0];
                mpbc_pkg::REG_DEBOUNCE:
                    cfg_reg.debounce_ms <= cfg_data[mpbc_pkg::TIME_WIDTH-1:0];
                mpbc_pkg::REG_FROM_LEVEL:
                    cfg_reg.from_level <= cfg_data[0];
                default:
                    ; // Unused index: the write is dropped.
            endcase
        end
    end

endmodule

>>> rtl/mpbc_core.sv
// Per-poll state update of the burst counter: seeding, gap timeout, debounce and press count.
`timescale 1ns / 1ps

module mpbc_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              pin_level,
    input  logic [mpbc_pkg::TIME_WIDTH-1:0]   now_ms,
    input  mpbc_pkg::cfg_t                    cfg,
    output mpbc_pkg::result_t                 res
);

    logic [mpbc_pkg::TIME_WIDTH-1:0]  gap_start_reg, gap_start_next;
    logic [mpbc_pkg::TIME_WIDTH-1:0]  last_sample_reg, last_sample_next;
    logic                             prev_level_reg, prev_level_next;
    logic                             seeded_reg;
    logic [mpbc_pkg::COUNT_WIDTH-1:0] press_count_reg, press_count_next;
    logic [mpbc_pkg::COUNT_WIDTH-1:0] latched_count_reg, latched_count_next;

    logic                            prev_eff;
    logic [mpbc_pkg::TIME_WIDTH-1:0] gap_eff;
    logic [mpbc_pkg::TIME_WIDTH-1:0] gap_elapsed;
    logic [mpbc_pkg::TIME_WIDTH-1:0] sample_elapsed;
    logic                            close_burst;
    logic                            take_sample;
    logic                            press_edge;

    // The very first poll seeds the level and the gap timer before it is judged.
    assign prev_eff = seeded_reg ? prev_level_reg : pin_level;
    assign gap_eff  = seeded_reg ? gap_start_reg : now_ms;

    // Modular differences wrap naturally at the timestamp width.
    assign gap_elapsed    = now_ms - gap_eff;
    assign sample_elapsed = now_ms - last_sample_reg;

    assign close_burst = gap_elapsed > cfg.repeat_gap_ms;
    assign take_sample = !close_burst && (sample_elapsed > cfg.debounce_ms);
    assign press_edge  = take_sample && (prev_eff == cfg.from_level)
                         && (pin_level != cfg.from_level);

    always_comb
    begin
        gap_start_next     = gap_eff;
        last_sample_next   = last_sample_reg;
        prev_level_next    = prev_eff;
        press_count_next   = press_count_reg;
        latched_count_next = latched_count_reg;
        if (close_burst)
        begin
            latched_count_next = press_count_reg;
            press_count_next   = '0;
            gap_start_next     = now_ms;
        end
        else if (take_sample)
        begin
            last_sample_next = now_ms;
            prev_level_next  = pin_level;
            if (press_edge)
            begin
                gap_start_next = now_ms;
                if (press_count_reg != mpbc_pkg::COUNT_MAX)
                begin
                    press_count_next = press_count_reg + 1'b1;
                end
            end
        end
    end

    assign res.burst_done  = close_burst && (press_count_reg != '0);
    assign res.burst_count = latched_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_start_reg     <= '0;
            last_sample_reg   <= '0;
            prev_level_reg    <= 1'b0;
            seeded_reg        <= 1'b0;
            press_count_reg   <= '0;
            latched_count_reg <= '0;
        end
        else if (accept)
        begin
            gap_start_reg     <= gap_start_next;
            last_sample_reg   <= last_sample_next;
            prev_level_reg    <= prev_level_next;
            seeded_reg        <= 1'b1;
            press_count_reg   <= press_count_next;
            latched_count_reg <= latched_count_next;
        end
    end

    a_seeded_after_poll: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> seeded_reg)
        else $error("state not seeded after a poll");

    a_count_cleared_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && close_burst |=> press_count_reg == '0)
        else $error("press count not cleared when a burst closed");

    a_done_has_presses: assert property (@(posedge clk) disable iff (!rst_n)
        res.burst_done |-> res.burst_count != '0)
        else $error("burst reported done with zero presses");

    a_idle_holds_counts: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(press_count_reg) && $stable(latched_count_reg))
        else $error("counts changed without a poll");

endmodule

>>> rtl/multi_press_burst_counter.sv
// Top level of the multi-press burst counter: stream ports, configuration and result register.
`timescale 1ns / 1ps

// The block takes one pin poll per beat, each carrying the pin level and a
// free-running millisecond timestamp, and returns exactly one result beat per
// poll. A press is an edge away from the idle level (from_level), seen only on
// polls that come more than debounce_ms after the last accepted sample. Once
// more than repeat_gap_ms passes after the last press (or after the last burst
// closed), the burst closes: burst_count shows the number of presses in it and
// burst_done is raised if that number is nonzero; no pin sample is taken on
// that poll. burst_count always shows the count of the most recent burst. All
// time differences wrap modulo 2^32, and the press count saturates at 255.
// The state update for each poll is a couple of subtract-and-compare steps,
// and the result lands in an output register in the cycle after the input
// beat, so a new poll is taken every cycle as long as the output side keeps
// up. Configuration should only be written while no result is waiting.
module multi_press_burst_counter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata, from bit 0 up: pin_level[0], now_ms[32:1], zero padding.
    input  logic [mpbc_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata, from bit 0 up: burst_done[0], burst_count[8:1], zero padding.
    output logic [mpbc_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
    // Configuration writes: index 0 repeat_gap_ms, 1 debounce_ms, 2 from_level.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mpbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mpbc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    mpbc_pkg::cfg_t    cfg;
    mpbc_pkg::result_t res;
    mpbc_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              in_accept;

    // A poll is taken whenever the result register is empty or drains this cycle.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    mpbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .pin_level (s_tdata[0]),
        .now_ms    (s_tdata[mpbc_pkg::TIME_WIDTH:1]),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mpbc_pkg::OUT_DATA_WIDTH'({out_reg.burst_count, out_reg.burst_done});

endmodule

>>> dv/tb_multi_press_burst_counter.sv
// Self-checking testbench for the multi-press burst counter: directed and random pin polls.
`timescale 1ns / 1ps

module tb_multi_press_burst_counter;

    import mpbc_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Tracks the burst state of the block from the polls it accepts and keeps
    // the result beats it still owes, oldest first.
    class burst_tracker;
        cfg_t                   regs;
        logic [TIME_WIDTH-1:0]  gap_start;
        logic [TIME_WIDTH-1:0]  last_sample;
        logic                   prev_level;
        logic                   seeded;
        logic [COUNT_WIDTH-1:0] presses;
        logic [COUNT_WIDTH-1:0] latched;
        result_t                reports_due[$];
        int unsigned            mismatches;
        int unsigned            reports_seen;
        int unsigned            bursts_closed;
        int unsigned            top_count;

        function new();
            regs.repeat_gap_ms = REPEAT_GAP_RESET;
            regs.debounce_ms   = DEBOUNCE_RESET;
            regs.from_level    = FROM_LEVEL_RESET;
            gap_start     = '0;
            last_sample   = '0;
            prev_level    = 1'b0;
            seeded        = 1'b0;
            presses       = '0;
            latched       = '0;
            mismatches    = 0;
            reports_seen  = 0;
            bursts_closed = 0;
            top_count     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                   logic [CFG_DATA_WIDTH-1:0] val);
            case (idx)
                REG_REPEAT_GAP: regs.repeat_gap_ms = val[TIME_WIDTH-1:0];
                REG_DEBOUNCE:   regs.debounce_ms   = val[TIME_WIDTH-1:0];
                REG_FROM_LEVEL: regs.from_level    = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return reports_due.size();
        endfunction

        // One accepted poll: update the burst state and queue the beat it causes.
        function void log_poll(logic pin, logic [TIME_WIDTH-1:0] stamp);
            result_t               r;
            logic [TIME_WIDTH-1:0] since_gap;
            logic [TIME_WIDTH-1:0] since_sample;
            r.burst_done = 1'b0;
            if (!seeded)
            begin
                prev_level = pin;
                gap_start  = stamp;
                seeded     = 1'b1;
            end
            since_gap    = stamp - gap_start;
            since_sample = stamp - last_sample;
            if (since_gap > regs.repeat_gap_ms)
            begin
                // The burst closes; the pin is not sampled on this poll.
                latched      = presses;
                presses      = '0;
                gap_start    = stamp;
                r.burst_done = (latched != '0);
            end
            else if (since_sample > regs.debounce_ms)
            begin
                if (prev_level == regs.from_level && pin != regs.from_level)
                begin
                    gap_start = stamp;
                    if (presses != COUNT_MAX)
                        presses = presses + 1'b1;
                end
                last_sample = stamp;
                prev_level  = pin;
            end
            r.burst_count = latched;
            reports_due.push_back(r);
        endfunction

        function void complain(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected done=%0d count=%0d, got done=%0d count=%0d",
                         $realtime, what, want.burst_done, want.burst_count,
                         got.burst_done, got.burst_count);
        endfunction

        function void match_report(result_t got);
            result_t want;
            reports_seen++;
            if (reports_due.size() == 0)
            begin
                want = '0;
                complain("result beat with nothing owed", want, got);
                return;
            end
            want = reports_due.pop_front();
            if (want.burst_done)
                bursts_closed++;
            if (want.burst_count > top_count)
                top_count = want.burst_count;
            if (got.burst_done !== want.burst_done || got.burst_count !== want.burst_count)
                complain("result mismatch", want, got);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_WIDTH-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0]  m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    burst_tracker          tracker = new();
    logic                  calm = 1'b0;     // no stalls on either side while set
    logic [TIME_WIDTH-1:0] clock_ms = '0;
    int unsigned           polls_sent = 0;
    int unsigned           config_writes = 0;
    int unsigned           cycles = 0;

    multi_press_burst_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d beats owed.",
                     cycles, tracker.outstanding());
            $display("tb_multi_press_burst_counter: FAIL");
            $finish;
        end
    end

    // Result side: stalls at random about a fifth of the time unless the run is calm.
    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99, 0) >= 21);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.match_report(result_t'(m_tdata[OUT_BITS-1:0]));

    // Called at a falling edge; returns at the falling edge after the beat was taken.
    task automatic send_poll(input logic pin, input logic [TIME_WIDTH-1:0] stamp);
        while (!calm && $urandom_range(99, 0) < 21)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_WIDTH'({stamp, pin});
        do
            @(posedge clk);
        while (!s_tready);
        tracker.log_poll(pin, stamp);
        polls_sent++;
        @(negedge clk);
    endtask

    task automatic poll_after(input logic pin, input logic [TIME_WIDTH-1:0] adv);
        clock_ms = clock_ms + adv;
        send_poll(pin, clock_ms);
    endtask

    // Stop sending and wait until every owed beat has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_register(idx, val);
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [TIME_WIDTH-1:0] gap,
                             input logic [TIME_WIDTH-1:0] deb,
                             input logic lvl);
        drain();
        write_reg(REG_REPEAT_GAP, gap);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_FROM_LEVEL, {31'($urandom()), lvl});
    endtask

    // A well-formed burst: re-arm at the idle level, one to six presses spaced
    // past the debounce window and inside the gap, an occasional bounce, then a
    // quiet poll long enough to close the burst.
    task automatic burst_sequence(input int unsigned gap, input int unsigned deb,
                                  input logic lvl);
        int unsigned presses;
        int unsigned spread;
        presses = $urandom_range(6, 1);
        spread  = gap / 2 - deb - 1;
        poll_after(lvl, deb + 1 + $urandom_range(spread, 0));
        repeat (presses)
        begin
            if ($urandom_range(3, 0) == 0)
                poll_after(!lvl, $urandom_range(deb, 0));
            poll_after(!lvl, deb + 1 + $urandom_range(spread, 0));
            poll_after(lvl, deb + 1 + $urandom_range(spread, 0));
        end
        poll_after(lvl, gap + 1 + $urandom_range(gap, 0));
    endtask

    initial
    begin
        int unsigned gap;
        int unsigned deb;
        int unsigned stop_at;
        int unsigned pick;
        logic        lvl;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: the first poll seeds the level, a bounce inside the
        // debounce window is ignored, two presses close into a burst, then a
        // burst closes with no presses at all.
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'd30);
        send_poll(1'b0, 32'd60);
        send_poll(1'b1, 32'd120);
        send_poll(1'b0, 32'd180);
        send_poll(1'b1, 32'd240);
        send_poll(1'b1, 32'd700);
        send_poll(1'b1, 32'd1200);

        // Timestamps that wrap through zero in the middle of a burst, then a
        // jump back to the top value.
        send_poll(1'b1, 32'hFFFF_FF00);
        send_poll(1'b0, 32'hFFFF_FF80);
        send_poll(1'b1, 32'h0000_0010);
        send_poll(1'b0, 32'h0000_0060);
        send_poll(1'b0, 32'hFFFF_FFFF);

        // Zero gap and zero debounce: every poll with a later timestamp closes a burst.
        configure(32'd0, 32'd0, 1'b1);
        send_poll(1'b1, 32'd5);
        send_poll(1'b0, 32'd5);
        send_poll(1'b0, 32'd6);
        send_poll(1'b1, 32'd6);

        // Largest gap and debounce: nothing is ever sampled or closed.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_poll(1'b0, 32'd1000);
        send_poll(1'b1, 32'h8000_0000);
        send_poll(1'b0, 32'd0);

        // An index past the register list must change nothing; the level
        // register keeps only its low bit, here selecting an idle-low pin.
        drain();
        write_reg(REG_UNUSED, $urandom());
        write_reg(REG_FROM_LEVEL, 32'hFFFF_FFFE);
        write_reg(REG_DEBOUNCE, 32'd0);
        write_reg(REG_REPEAT_GAP, 32'd400);
        send_poll(1'b1, 32'd100);
        send_poll(1'b0, 32'd200);
        send_poll(1'b1, 32'd300);
        send_poll(1'b0, 32'd350);
        send_poll(1'b0, 32'd900);

        // One long burst with no stalls anywhere; a short gap written
        // afterward closes it.
        configure(32'hFFFF_FFFF, 32'd0, 1'b1);
        calm = 1'b1;
        clock_ms = $urandom();
        repeat (60)
        begin
            poll_after(1'b0, 32'd1);
            poll_after(1'b1, 32'd1);
        end
        configure(32'd10, 32'd0, 1'b1);
        poll_after(1'b1, 32'd100);
        calm = 1'b0;

        // Random phases: mostly proper bursts, with stray polls and large time
        // jumps mixed in. Every settings change waits for the block to empty.
        for (int phase = 0; phase < 4; phase++)
        begin
            gap = $urandom_range(600, 8);
            deb = $urandom_range(gap / 4, 0);
            lvl = 1'($urandom_range(1, 0));
            configure(gap, deb, lvl);
            clock_ms = $urandom();
            stop_at  = polls_sent + 70;
            while (polls_sent < stop_at)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    burst_sequence(gap, deb, lvl);
                else if (pick < 85)
                    poll_after(1'($urandom_range(1, 0)), $urandom_range(2 * gap, 0));
                else
                    poll_after(1'($urandom_range(1, 0)), $urandom());
            end
        end

        drain();
        repeat (8) @(negedge clk);

        $display("Run covered %0d polls, %0d result beats and %0d register writes.",
                 polls_sent, tracker.reports_seen, config_writes);
        $display("Bursts reported: %0d, largest count %0d, mismatches %0d.",
                 tracker.bursts_closed, tracker.top_count, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("tb_multi_press_burst_counter: PASS");
        else
            $display("tb_multi_press_burst_counter: FAIL");
        $finish;
    end

endmodule
